// File: rtl/core/lrsp_pkg.sv
// Package: shared types, constants and helper functions for the LED ring slot PWM
`timescale 1ns / 1ps

package lrsp_pkg;

    // Geometry of the ring and of the PWM period
    localparam int LED_COUNT  = 8;
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    localparam int LEVEL_W    = 5;
    localparam int CMP_W      = 6;   // common width for level vs. slot compare
    localparam int IDX_W      = 3;
    localparam int ANGLE_W    = 8;
    localparam int WORD_W     = 16;
    localparam int SLOT_OUT_W = 4;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL  = 5'd16;
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(SLOT_COUNT - 1);

    // Transaction kinds
    localparam logic [1:0] KIND_SET_LEVEL = 2'd0;
    localparam logic [1:0] KIND_SET_ANGLE = 2'd1;
    localparam logic [1:0] KIND_TICK      = 2'd2;

    // GPIO pin for each LED: LED 0..6 on pins 9..15, LED 7 on pin 8
    localparam logic [3:0] PIN_OF_LED [LED_COUNT] = '{
        4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd8
    };

    typedef logic [LED_COUNT-1:0][LEVEL_W-1:0] t_level_arr;

    typedef struct packed {
        logic [1:0]         kind;
        logic [IDX_W-1:0]   led_index;
        logic [LEVEL_W-1:0] level;
        logic [ANGLE_W-1:0] angle;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]     pin_word;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  end_of_period;
    } t_out_item;

    // Level update command from the input stage to the level store
    typedef struct packed {
        logic               set_one;
        logic               set_angle;
        logic [IDX_W-1:0]   led_index;
        logic [LEVEL_W-1:0] level;
        logic [ANGLE_W-1:0] angle;
    } t_level_cmd;

    // Clamp a requested level to the top brightness
    function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] lvl);
        sat_level = (lvl > MAX_LEVEL) ? MAX_LEVEL : lvl;
    endfunction

    // Brightness of one LED for a pointer angle: 15 - |d|/2, zero beyond 31
    function automatic logic [LEVEL_W-1:0] level_from_angle(
        input logic [ANGLE_W-1:0] angle,
        input logic [IDX_W-1:0]   led
    );
        logic [ANGLE_W-1:0] pole;
        logic [ANGLE_W-1:0] diff;
        logic [ANGLE_W-1:0] mag;
        pole = {led, 5'b0};
        diff = angle - pole;
        mag  = diff[ANGLE_W-1] ? (~diff + 8'd1) : diff;
        if (mag > 8'd31) begin
            level_from_angle = '0;
        end else begin
            level_from_angle = LEVEL_W'(4'd15 - mag[4:1]);
        end
    endfunction

    // Place per-LED on bits onto their GPIO pins
    function automatic logic [WORD_W-1:0] pins_from_leds(input logic [LED_COUNT-1:0] on);
        logic [WORD_W-1:0] word;
        word = '0;
        for (int i = 0; i < LED_COUNT; i++) begin
            word[PIN_OF_LED[i]] = on[i];
        end
        pins_from_leds = word;
    endfunction

endpackage

// File: rtl/core/led_ring_slot_pwm.sv
// Top level: input register, level store and slot output for the LED ring PWM
// Path: an accepted tick is held in the input register, then its result is
//   registered in the result register, from which it is taken.
// Throughput: one transaction per cycle; the input register holds while a
//   tick waits for a full, stalled result register.
// Reset: synchronous active-low i_rst_n clears all levels, the slot counter
//   and both valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module led_ring_slot_pwm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lrsp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lrsp_pkg::t_out_item o_out_data
);

    logic                 r_in_valid;
    logic                 n_in_valid;
    lrsp_pkg::t_in_item   r_in_item;
    logic                 w_can_load;
    logic                 w_is_tick;
    logic                 w_fire;
    logic                 w_tick;
    lrsp_pkg::t_level_cmd w_cmd;
    lrsp_pkg::t_level_arr w_levels;

    // Stage control: the held transaction retires unless it is a blocked tick
    assign w_is_tick  = (r_in_item.kind == lrsp_pkg::KIND_TICK);
    assign w_fire     = r_in_valid && (!w_is_tick || w_can_load);
    assign w_tick     = w_fire && w_is_tick;
    assign o_in_ready = !r_in_valid || w_fire;
    assign n_in_valid = (i_in_valid && o_in_ready) || (r_in_valid && !w_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // Level update command
    always_comb begin
        w_cmd.set_one   = w_fire && (r_in_item.kind == lrsp_pkg::KIND_SET_LEVEL);
        w_cmd.set_angle = w_fire && (r_in_item.kind == lrsp_pkg::KIND_SET_ANGLE);
        w_cmd.led_index = r_in_item.led_index;
        w_cmd.level     = r_in_item.level;
        w_cmd.angle     = r_in_item.angle;
    end

    lrsp_level_store u_level_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_levels (w_levels)
    );

    lrsp_slot_out u_slot_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_tick),
        .i_levels    (w_levels),
        .i_out_ready (i_out_ready),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Input backpressure only comes from a tick stuck behind a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && w_is_tick && o_out_valid && !i_out_ready))
        else $error("input stalled without a blocked tick");

endmodule

// File: rtl/core/lrsp_level_store.sv
// Level store: per-LED brightness registers with single-LED and angle updates
`timescale 1ns / 1ps

module lrsp_level_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lrsp_pkg::t_level_cmd i_cmd,
    output lrsp_pkg::t_level_arr o_levels
);

    lrsp_pkg::t_level_arr r_level;
    lrsp_pkg::t_level_arr n_level;

    // Next levels: one LED from the command, or all eight from the angle
    always_comb begin
        n_level = r_level;
        if (i_cmd.set_one) begin
            n_level[i_cmd.led_index] = lrsp_pkg::sat_level(i_cmd.level);
        end else if (i_cmd.set_angle) begin
            for (int i = 0; i < lrsp_pkg::LED_COUNT; i++) begin
                n_level[i] = lrsp_pkg::level_from_angle(i_cmd.angle,
                                                        lrsp_pkg::IDX_W'(i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    assign o_levels = r_level;

    // No stored level ever exceeds full brightness
    for (genvar g = 0; g < lrsp_pkg::LED_COUNT; g++) begin : g_chk
        a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_level[g] <= lrsp_pkg::MAX_LEVEL)
            else $error("stored level above maximum");
    end

endmodule

// File: rtl/core/lrsp_slot_out.sv
// Slot output: slot counter, level compare and the result register
`timescale 1ns / 1ps

module lrsp_slot_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  lrsp_pkg::t_level_arr i_levels,
    input  logic                 i_out_ready,
    output logic                 o_can_load,
    output logic                 o_out_valid,
    output lrsp_pkg::t_out_item  o_out_data
);

    logic [lrsp_pkg::SLOT_W-1:0]    r_slot;
    logic [lrsp_pkg::SLOT_W-1:0]    n_slot;
    logic                           r_out_valid;
    logic                           n_out_valid;
    lrsp_pkg::t_out_item            r_out_data;
    lrsp_pkg::t_out_item            n_out_data;
    logic [lrsp_pkg::CMP_W-1:0]     w_slot_ext;
    logic [lrsp_pkg::LED_COUNT-1:0] w_on;

    assign o_can_load = !r_out_valid || i_out_ready;

    // Compare every level against the current slot
    always_comb begin
        w_slot_ext = lrsp_pkg::CMP_W'(r_slot);
        for (int i = 0; i < lrsp_pkg::LED_COUNT; i++) begin
            w_on[i] = lrsp_pkg::CMP_W'(i_levels[i]) > w_slot_ext;
        end
    end

    // Next slot and result register contents
    always_comb begin
        n_slot      = r_slot;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (i_tick) begin
            n_slot                   = (r_slot == lrsp_pkg::SLOT_LAST) ? '0 : r_slot + 1'b1;
            n_out_valid              = 1'b1;
            n_out_data.pin_word      = lrsp_pkg::pins_from_leds(w_on);
            n_out_data.slot          = w_slot_ext[lrsp_pkg::SLOT_OUT_W-1:0];
            n_out_data.end_of_period = (r_slot == lrsp_pkg::SLOT_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Slot counter stays inside the period
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= lrsp_pkg::SLOT_LAST)
        else $error("slot counter out of range");

    // A tick moves the counter one slot forward, wrapping at the end
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |=> (r_slot == (($past(r_slot) == lrsp_pkg::SLOT_LAST) ? '0
                               : $past(r_slot) + 1'b1)))
        else $error("slot counter did not advance");

    // A tick is only issued when the result register can take it
    a_tick_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |-> o_can_load)
        else $error("tick issued into a full result register");

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the LED ring slot PWM: queued stimulus, clocked driver and monitor, local model
`timescale 1ns / 1ps

module tb_top;

    // Kind code the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    localparam int MID_DRAIN    = 600;   // random item that waits for all slot words
    localparam int IDLE_PCT     = 16;
    localparam int CALM_FIRST   = 300;   // window of issued items with no idling
    localparam int CALM_LAST    = 560;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        lrsp_pkg::t_in_item item;
        bit                 drain;
    } t_pending;

    typedef struct {
        logic [lrsp_pkg::WORD_W-1:0]     pin_word;
        logic [lrsp_pkg::SLOT_OUT_W-1:0] slot;
        logic                            end_of_period;
    } t_slot_word;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    lrsp_pkg::t_in_item  in_data   = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    lrsp_pkg::t_out_item out_data;

    t_pending   pending_q[$];
    t_slot_word slot_word_q[$];

    // Model state
    logic [lrsp_pkg::LEVEL_W-1:0] led_level [lrsp_pkg::LED_COUNT];
    int                           slot_pos;

    int   issued_count   = 0;
    int   error_count    = 0;
    int   stall_cycles   = 0;
    logic words_drained  = 1'b1;
    logic calm;

    assign calm = (issued_count >= CALM_FIRST) && (issued_count < CALM_LAST);

    led_ring_slot_pwm u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Brightness of one LED for a pointer angle
    function automatic logic [lrsp_pkg::LEVEL_W-1:0] ring_level(
        input logic [lrsp_pkg::ANGLE_W-1:0] angle,
        input int                           led
    );
        logic [lrsp_pkg::ANGLE_W-1:0] offset;
        int                           mag;
        offset = angle - lrsp_pkg::ANGLE_W'(led * 32);
        mag    = $signed(offset);
        if (mag < 0) begin
            mag = -mag;
        end
        return (mag > 31) ? '0 : lrsp_pkg::LEVEL_W'(15 - mag / 2);
    endfunction

    // Update the model for one accepted transaction; a tick queues its slot word
    task automatic apply_transaction(input lrsp_pkg::t_in_item it);
        t_slot_word w;
        case (it.kind)
            lrsp_pkg::KIND_SET_LEVEL: begin
                led_level[it.led_index] = (it.level > lrsp_pkg::MAX_LEVEL)
                                          ? lrsp_pkg::MAX_LEVEL : it.level;
            end
            lrsp_pkg::KIND_SET_ANGLE: begin
                for (int i = 0; i < lrsp_pkg::LED_COUNT; i++) begin
                    led_level[i] = ring_level(it.angle, i);
                end
            end
            lrsp_pkg::KIND_TICK: begin
                w.pin_word = '0;
                for (int i = 0; i < lrsp_pkg::LED_COUNT; i++) begin
                    // LED 0..6 on pins 9..15, LED 7 wraps to pin 8
                    if (int'(led_level[i]) > slot_pos) begin
                        w.pin_word[8 + (i + 1) % 8] = 1'b1;
                    end
                end
                w.slot          = lrsp_pkg::SLOT_OUT_W'(slot_pos);
                w.end_of_period = (slot_pos == lrsp_pkg::SLOT_COUNT - 1);
                slot_word_q.push_back(w);
                slot_pos = (slot_pos + 1 >= lrsp_pkg::SLOT_COUNT) ? 0 : slot_pos + 1;
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic queue_item(input logic [1:0] kind, input int idx, input int lvl,
                              input int ang, input bit drain);
        t_pending p;
        p.item.kind      = kind;
        p.item.led_index = lrsp_pkg::IDX_W'(idx);
        p.item.level     = lrsp_pkg::LEVEL_W'(lvl);
        p.item.angle     = lrsp_pkg::ANGLE_W'(ang);
        p.drain          = drain;
        pending_q.push_back(p);
    endtask

    // Driver: one transaction from the pending queue, random idle cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pending_q.size() != 0
                && (!pending_q[0].drain || (!in_valid && words_drained))
                && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_valid     <= 1'b1;
                in_data      <= pending_q[0].item;
                issued_count <= issued_count + 1;
                pending_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: check slot words first, then feed accepted transactions to the model
    always @(posedge i_clk) begin
        t_slot_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < lrsp_pkg::LED_COUNT; i++) begin
                led_level[i] = '0;
            end
            slot_pos     = 0;
            stall_cycles <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (slot_word_q.size() == 0) begin
                    report_mismatch("unexpected slot word", out_data.pin_word, 0);
                end else begin
                    want = slot_word_q.pop_front();
                    if (out_data.pin_word !== want.pin_word)
                        report_mismatch("pin_word", out_data.pin_word, want.pin_word);
                    if (out_data.slot !== want.slot)
                        report_mismatch("slot", out_data.slot, want.slot);
                    if (out_data.end_of_period !== want.end_of_period)
                        report_mismatch("end_of_period", out_data.end_of_period,
                                        want.end_of_period);
                end
            end
            if (in_valid && in_ready) begin
                apply_transaction(in_data);
            end
            stall_cycles <= ((in_valid && in_ready) || (out_valid && out_ready))
                            ? 0 : stall_cycles + 1;
        end
        words_drained <= (slot_word_q.size() == 0);
        // Watchdog
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL led_ring_slot_pwm");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int counted;
        int pick;
        bit drain;

        // Directed: saturation, all LEDs, ignored kind, ticks, angle edge cases
        queue_item(lrsp_pkg::KIND_SET_LEVEL, 0, 31, 8'hA5, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_LEVEL, 1, 17, 8'h5A, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_LEVEL, 2, 16, 8'hFF, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_LEVEL, 3, 0, 8'h00, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_LEVEL, 4, 15, 8'h12, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_LEVEL, 5, 1, 8'h34, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_LEVEL, 6, 8, 8'h56, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_LEVEL, 7, 20, 8'h78, 1'b0);
        queue_item(KIND_UNUSED, 7, 31, 8'hFF, 1'b0);
        repeat (6) queue_item(lrsp_pkg::KIND_TICK, 7, 31, 8'hFF, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_ANGLE, 0, 0, 8'h80, 1'b0);   // half turn from LED 0
        repeat (2) queue_item(lrsp_pkg::KIND_TICK, 0, 0, 8'h00, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_ANGLE, 5, 9, 8'hF1, 1'b0);
        repeat (2) queue_item(lrsp_pkg::KIND_TICK, 2, 3, 8'h44, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_ANGLE, 0, 0, 8'h00, 1'b0);
        queue_item(lrsp_pkg::KIND_TICK, 1, 1, 8'h01, 1'b0);
        queue_item(lrsp_pkg::KIND_SET_ANGLE, 3, 2, 8'h3F, 1'b0);
        queue_item(lrsp_pkg::KIND_TICK, 6, 30, 8'hC3, 1'b0);

        // Random mix, ignored kind included
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            drain = (counted == 0) || (counted == MID_DRAIN);
            pick  = $urandom_range(0, 99);
            if (pick < 45) begin
                queue_item(lrsp_pkg::KIND_TICK, $urandom_range(0, 7), $urandom_range(0, 31),
                           $urandom_range(0, 255), drain);
            end else if (pick < 72) begin
                queue_item(lrsp_pkg::KIND_SET_LEVEL, $urandom_range(0, 7),
                           $urandom_range(0, 31), $urandom_range(0, 255), drain);
            end else if (pick < 92) begin
                queue_item(lrsp_pkg::KIND_SET_ANGLE, $urandom_range(0, 7),
                           $urandom_range(0, 31), $urandom_range(0, 255), drain);
            end else begin
                queue_item(KIND_UNUSED, $urandom_range(0, 7), $urandom_range(0, 31),
                           $urandom_range(0, 255), drain);
            end
            counted++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (pending_q.size() != 0 || in_valid || !words_drained);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS led_ring_slot_pwm");
        end else begin
            $display("FAIL led_ring_slot_pwm");
        end
        $finish;
    end

endmodule

// File: led_ring_slot_pwm.f
rtl/core/lrsp_pkg.sv
rtl/core/lrsp_level_store.sv
rtl/core/lrsp_slot_out.sv
rtl/core/led_ring_slot_pwm.sv
tb/sv/tb_top.sv
